### design/ppc_pkg.sv
// shared constants and types for the plane clipper
package ppc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int NORM_W    = 18;
  localparam int OFFS_W    = 32;
  localparam int EPS_W     = 16;
  localparam int DIST_W    = 40;
  localparam int MA_W      = COORD_W + 2;
  localparam int MB_W      = NORM_W;
  localparam int MR_W      = MA_W + MB_W - FRAC_BITS;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DCNT_W    = $clog2(FRAC_BITS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONE     = 3'd7;

  localparam logic [1:0] KIND_KEPT  = 2'd0;
  localparam logic [1:0] KIND_ISECT = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIST_W-1:0]  dist_t;
endpackage

### design/ppc_mul.sv
// shared signed multiplier with registered arithmetic shift by the fraction bits
module ppc_mul (
  input  logic                          clk,
  input  logic signed [ppc_pkg::MA_W-1:0] a,
  input  logic signed [ppc_pkg::MB_W-1:0] b,
  output logic signed [ppc_pkg::MR_W-1:0] res_r
);
  import ppc_pkg::*;

  logic signed [MA_W+MB_W-1:0] prod;
  logic signed [MA_W+MB_W-1:0] shifted;
  logic signed [MR_W-1:0]      res_nxt;

  assign prod    = a * b;
  assign shifted = prod >>> FRAC_BITS;
  assign res_nxt = shifted[MR_W-1:0];

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end
endmodule

### design/ppc_div.sv
// serial restoring divider for the edge fraction, one quotient bit per cycle
module ppc_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ppc_pkg::DIST_W-1:0]      num,
  input  logic [ppc_pkg::DIST_W:0]        den,
  output logic                            done,
  output logic [ppc_pkg::FRAC_BITS-1:0]   quo
);
  import ppc_pkg::*;

  logic [DIST_W+1:0]    rem_r, rem_nxt;
  logic [DIST_W:0]      den_r, den_nxt;
  logic [FRAC_BITS-1:0] quo_r, quo_nxt;
  logic [DCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic [DIST_W+1:0]    shl;

  assign shl = {rem_r[DIST_W:0], 1'b0};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = {2'b00, num};
      den_nxt  = den;
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shl >= {1'b0, den_r}) begin
        rem_nxt = shl - {1'b0, den_r};
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shl;
        quo_nxt = {quo_r[FRAC_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DCNT_W'(FRAC_BITS - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done = busy_r && (cnt_r == DCNT_W'(FRAC_BITS - 1));
  assign quo  = quo_nxt;
endmodule

### design/polygon_plane_clip_core.sv
// single plane polygon clipper: sequencer around a shared multiplier and a serial divider
// each emitted beat also waits for out_ready
// a crossing edge adds a serial divide of 16 quotient bits and a multiplier pass for each coordinate
// one vertex at a time: in_ready is high only while the sequencer is idle
// rst_n synchronous active low: registers to defaults, polygon state cleared
module polygon_plane_clip_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppc_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [ppc_pkg::COORD_W-1:0] in_vertex_x,
  input  logic signed [ppc_pkg::COORD_W-1:0] in_vertex_y,
  input  logic signed [ppc_pkg::COORD_W-1:0] in_vertex_z,
  input  logic                            in_final_vertex,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [ppc_pkg::COORD_W-1:0] out_x,
  output logic signed [ppc_pkg::COORD_W-1:0] out_y,
  output logic signed [ppc_pkg::COORD_W-1:0] out_z,
  output logic [1:0]                      out_vertex_kind,
  output logic                            out_final_result
);
  import ppc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DIST  = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_KEEP  = 4'd3;
  localparam logic [3:0] S_WAITK = 4'd4;
  localparam logic [3:0] S_CROSS = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_LERP  = 4'd7;
  localparam logic [3:0] S_WAITI = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_WAITM = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic signed [NORM_W-1:0] nrm_r [3];
  logic signed [OFFS_W-1:0] offs_r;
  logic [EPS_W-1:0]         eps_r;

  coord_t cur_r [3], cur_nxt [3];
  coord_t prv_r [3], prv_nxt [3];
  coord_t fst_r [3], fst_nxt [3];
  coord_t oc_r  [3], oc_nxt  [3];
  dist_t  d_r, d_nxt, dprv_r, dprv_nxt, dfst_r, dfst_nxt, acc_r, acc_nxt;
  logic   last_r, last_nxt, have_r, have_nxt, edge_r, edge_nxt, emit_r, emit_nxt;
  logic   ov_r, ov_nxt, ofin_r, ofin_nxt;
  logic [1:0] okind_r, okind_nxt;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [MR_W-1:0] mres;
  dist_t  mres_d;
  logic [1:0] sel;

  coord_t p1 [3];
  coord_t p2 [3];
  dist_t  d1, d2, epsp, epsn;
  logic   cross_cur, e1_emit, keep_cur;
  logic   div_start, div_done;
  logic [DIST_W-1:0]    abs1, abs2;
  logic [DIST_W:0]      den;
  logic [FRAC_BITS-1:0] tq, t_r, t_nxt;

  ppc_mul u_mul (.clk(clk), .a(ma), .b(mb), .res_r(mres));

  ppc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(abs1), .den(den),
    .done(div_done), .quo(tq)
  );

  assign epsp   = {{(DIST_W-EPS_W){1'b0}}, eps_r};
  assign epsn   = -epsp;
  assign mres_d = {{(DIST_W-MR_W){mres[MR_W-1]}}, mres};
  assign sel    = (cnt_r == 2'd3) ? 2'd2 : cnt_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      p1[k] = edge_r ? cur_r[k] : prv_r[k];
      p2[k] = edge_r ? fst_r[k] : cur_r[k];
    end
    d1 = edge_r ? d_r : dprv_r;
    d2 = edge_r ? dfst_r : d_r;
  end

  assign keep_cur  = (d1 <= epsp);
  assign cross_cur = ((d1 > epsp) && (d2 < epsn)) || ((d1 < epsn) && (d2 > epsp));
  assign e1_emit   = (d_r <= epsp) || ((d_r > epsp) && (dfst_r < epsn)) ||
                     ((d_r < epsn) && (dfst_r > epsp));
  assign abs1 = d1[DIST_W-1] ? DIST_W'(~d1 + 1'b1) : DIST_W'(d1);
  assign abs2 = d2[DIST_W-1] ? DIST_W'(~d2 + 1'b1) : DIST_W'(d2);
  assign den  = {1'b0, abs1} + {1'b0, abs2};

  always_comb begin
    if (state_r == S_LERP) begin
      ma = MA_W'(p2[sel]) - MA_W'(p1[sel]);
      mb = {{(MB_W-FRAC_BITS){1'b0}}, t_r};
    end else begin
      ma = MA_W'(cur_r[sel]);
      mb = nrm_r[sel];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    prv_nxt   = prv_r;
    fst_nxt   = fst_r;
    oc_nxt    = oc_r;
    d_nxt     = d_r;
    dprv_nxt  = dprv_r;
    dfst_nxt  = dfst_r;
    acc_nxt   = acc_r;
    last_nxt  = last_r;
    have_nxt  = have_r;
    edge_nxt  = edge_r;
    emit_nxt  = emit_r;
    ov_nxt    = ov_r;
    ofin_nxt  = ofin_r;
    okind_nxt = okind_r;
    t_nxt     = t_r;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cur_nxt[0] = in_vertex_x;
          cur_nxt[1] = in_vertex_y;
          cur_nxt[2] = in_vertex_z;
          last_nxt   = in_final_vertex;
          acc_nxt    = '0;
          cnt_nxt    = '0;
          emit_nxt   = 1'b0;
          state_nxt  = S_DIST;
        end
      end
      S_DIST: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != 2'd0) acc_nxt = acc_r + mres_d;
        if (cnt_r == 2'd3) begin
          d_nxt     = acc_r + mres_d - DIST_W'(offs_r);
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (have_r) begin
          edge_nxt  = 1'b0;
          state_nxt = S_KEEP;
        end else begin
          fst_nxt   = cur_r;
          dfst_nxt  = d_r;
          have_nxt  = 1'b1;
          edge_nxt  = 1'b1;
          state_nxt = last_r ? S_KEEP : S_DONE;
        end
      end
      S_KEEP: begin
        if (keep_cur) begin
          oc_nxt    = p1;
          okind_nxt = KIND_KEPT;
          ofin_nxt  = edge_r ? !cross_cur : (last_r && !cross_cur && !e1_emit);
          ov_nxt    = 1'b1;
          emit_nxt  = 1'b1;
          state_nxt = S_WAITK;
        end else begin
          state_nxt = S_CROSS;
        end
      end
      S_WAITK: begin
        if (out_ready) begin
          ov_nxt    = 1'b0;
          state_nxt = S_CROSS;
        end
      end
      S_CROSS: begin
        if (cross_cur) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          t_nxt     = tq;
          cnt_nxt   = '0;
          state_nxt = S_LERP;
        end
      end
      S_LERP: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != 2'd0) begin
          oc_nxt[cnt_r - 2'd1] = p1[cnt_r - 2'd1] + mres[COORD_W-1:0];
        end
        if (cnt_r == 2'd3) begin
          okind_nxt = KIND_ISECT;
          ofin_nxt  = edge_r ? 1'b1 : (last_r && !e1_emit);
          ov_nxt    = 1'b1;
          emit_nxt  = 1'b1;
          state_nxt = S_WAITI;
        end
      end
      S_WAITI: begin
        if (out_ready) begin
          ov_nxt    = 1'b0;
          state_nxt = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!edge_r && last_r) begin
          edge_nxt  = 1'b1;
          state_nxt = S_KEEP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        prv_nxt  = cur_r;
        dprv_nxt = d_r;
        if (last_r) have_nxt = 1'b0;
        if (last_r && !emit_r) begin
          for (int k = 0; k < 3; k++) oc_nxt[k] = '0;
          okind_nxt = KIND_MARK;
          ofin_nxt  = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_WAITM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WAITM: begin
        if (out_ready) begin
          ov_nxt    = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      have_r   <= 1'b0;
      ov_r     <= 1'b0;
      emit_r   <= 1'b0;
      edge_r   <= 1'b0;
      last_r   <= 1'b0;
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= NORM_W'(1 << FRAC_BITS);
      offs_r   <= '0;
      eps_r    <= EPS_W'(655);
      for (int k = 0; k < 3; k++) begin
        prv_r[k] <= '0;
        fst_r[k] <= '0;
      end
      dprv_r <= '0;
      dfst_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      have_r  <= have_nxt;
      ov_r    <= ov_nxt;
      emit_r  <= emit_nxt;
      edge_r  <= edge_nxt;
      last_r  <= last_nxt;
      prv_r   <= prv_nxt;
      fst_r   <= fst_nxt;
      dprv_r  <= dprv_nxt;
      dfst_r  <= dfst_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_NORMAL_X: nrm_r[0] <= cfg_wdata[NORM_W-1:0];
          REG_NORMAL_Y: nrm_r[1] <= cfg_wdata[NORM_W-1:0];
          REG_NORMAL_Z: nrm_r[2] <= cfg_wdata[NORM_W-1:0];
          REG_OFFSET:   offs_r   <= cfg_wdata[OFFS_W-1:0];
          REG_EPSILON:  eps_r    <= cfg_wdata[EPS_W-1:0];
          default: ;
        endcase
      end
    end
    cur_r   <= cur_nxt;
    oc_r    <= oc_nxt;
    d_r     <= d_nxt;
    acc_r   <= acc_nxt;
    ofin_r  <= ofin_nxt;
    okind_r <= okind_nxt;
    t_r     <= t_nxt;
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = ov_r;
  assign out_x            = oc_r[0];
  assign out_y            = oc_r[1];
  assign out_z            = oc_r[2];
  assign out_vertex_kind  = okind_r;
  assign out_final_result = ofin_r;

  a_ready_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("input taken while a beat is pending");

  a_accept_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DIST)) else $error("accept did not start");

  a_marker_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_vertex_kind == KIND_MARK) |-> out_final_result)
    else $error("marker beat without final flag");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_final_result)))
    else $error("stalled beat changed");
endmodule

### dv/polygon_plane_clip_core_chk.sv
// scoreboard for the plane clipper: predicts clipped vertices and compares output beats
`timescale 1ns / 100ps
module polygon_plane_clip_core_chk (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ppc_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  ppc_pkg::coord_t               in_vertex_x,
  input  ppc_pkg::coord_t               in_vertex_y,
  input  ppc_pkg::coord_t               in_vertex_z,
  input  logic                          in_final_vertex,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  ppc_pkg::coord_t               out_x,
  input  ppc_pkg::coord_t               out_y,
  input  ppc_pkg::coord_t               out_z,
  input  logic [1:0]                    out_vertex_kind,
  input  logic                          out_final_result,
  output int                            fail_count,
  output int                            pending_count
);
  import ppc_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [1:0]         kind;
    logic               last;
  } clip_vtx_t;

  clip_vtx_t clip_q[$];
  longint nx, ny, nz, offs, eps;
  longint first_v[3], prev_v[3];
  longint prev_d, first_d;
  bit     have_first;

  assign pending_count = clip_q.size();

  function automatic longint fshr(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint plane_dist(longint x, longint y, longint z);
    return fshr(nx * x) + fshr(ny * y) + fshr(nz * z) - offs;
  endfunction

  function automatic longint lerp_coord(longint p1, longint p2, longint t);
    return p1 + fshr((p2 - p1) * t);
  endfunction

  task automatic clip_edge(longint p1[3], longint d1, longint p2[3], longint d2,
                           inout int n);
    clip_vtx_t e;
    longint a, b, r, t;
    if (d1 <= eps) begin
      e = '{p1[0][31:0], p1[1][31:0], p1[2][31:0], KIND_KEPT, 1'b0};
      clip_q = {clip_q, e};
      n++;
    end
    if ((d1 > eps && d2 < -eps) || (d1 < -eps && d2 > eps)) begin
      a = d1 < 0 ? -d1 : d1;
      b = a + (d2 < 0 ? -d2 : d2);
      r = a;
      t = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        t = t << 1;
        if (r >= b) begin
          r = r - b;
          t = t | 1;
        end
      end
      e.x = 32'(lerp_coord(p1[0], p2[0], t));
      e.y = 32'(lerp_coord(p1[1], p2[1], t));
      e.z = 32'(lerp_coord(p1[2], p2[2], t));
      e.kind = KIND_ISECT;
      e.last = 1'b0;
      clip_q = {clip_q, e};
      n++;
    end
  endtask

  task automatic predict_vertex(coord_t x, coord_t y, coord_t z, logic fin);
    longint v[3];
    longint d;
    int n;
    clip_vtx_t e;
    n = 0;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    d = plane_dist(v[0], v[1], v[2]);
    if (!have_first) begin
      first_v = v;
      first_d = d;
      have_first = 1;
    end else begin
      clip_edge(prev_v, prev_d, v, d, n);
    end
    prev_v = v;
    prev_d = d;
    if (fin) begin
      clip_edge(v, d, first_v, first_d, n);
      if (n == 0) begin
        e = '{32'd0, 32'd0, 32'd0, KIND_MARK, 1'b1};
        clip_q = {clip_q, e};
      end else begin
        clip_q[$].last = 1'b1;
      end
      have_first = 0;
    end
  endtask

  always @(posedge clk) begin
    clip_vtx_t e;
    if (!rst_n) begin
      nx <= 0; ny <= 0; nz <= 65536; offs <= 0; eps <= 655;
      have_first = 0;
      clip_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NORMAL_X: nx <= longint'($signed(cfg_wdata[NORM_W-1:0]));
          REG_NORMAL_Y: ny <= longint'($signed(cfg_wdata[NORM_W-1:0]));
          REG_NORMAL_Z: nz <= longint'($signed(cfg_wdata[NORM_W-1:0]));
          REG_OFFSET:   offs <= longint'($signed(cfg_wdata[OFFS_W-1:0]));
          REG_EPSILON:  eps <= longint'(cfg_wdata[EPS_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_vertex(in_vertex_x, in_vertex_y, in_vertex_z, in_final_vertex);
      if (out_valid && out_ready) begin
        if (clip_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected beat x=%h y=%h z=%h kind=%0d last=%b",
                     out_x, out_y, out_z, out_vertex_kind, out_final_result);
          fail_count <= fail_count + 1;
        end else begin
          e = clip_q.pop_front();
          if (e != {out_x, out_y, out_z, out_vertex_kind, out_final_result}) begin
            if (fail_count < 10)
              $display("mismatch exp x=%h y=%h z=%h k=%0d l=%b got x=%h y=%h z=%h k=%0d l=%b",
                       e.x, e.y, e.z, e.kind, e.last,
                       out_x, out_y, out_z, out_vertex_kind, out_final_result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### dv/polygon_plane_clip_core_tb.sv
// testbench top for the plane clipper: stimulus, configuration phases and verdict
`timescale 1ns / 100ps
module polygon_plane_clip_core_tb;
  import ppc_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  coord_t               in_vertex_x, in_vertex_y, in_vertex_z;
  logic                 in_final_vertex;
  logic                 out_valid;
  logic                 out_ready;
  coord_t               out_x, out_y, out_z;
  logic [1:0]           out_vertex_kind;
  logic                 out_final_result;
  int                   fail_count, pending_count;
  int                   burst_left;
  bit                   in_hold;

  polygon_plane_clip_core uut (.*);

  polygon_plane_clip_core_chk chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("[polygon_plane_clip_core] ERROR");
    $finish;
  end

  // receiver stall pattern
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      case ($urandom_range(3))
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(3) != 0);
        2: out_ready <= ($urandom_range(1) != 0);
        default: out_ready <= ($urandom_range(5) == 0);
      endcase
    end
  end

  task automatic send_vertex(coord_t x, coord_t y, coord_t z, logic fin);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_hold = 1;
    in_vertex_x <= x;
    in_vertex_y <= y;
    in_vertex_z <= z;
    in_final_vertex <= fin;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (burst_left == 0 || $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      in_hold = 0;
      if (burst_left != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    if (in_hold) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $signed($urandom_range(0, 32'h0000_7FFF)) - 32'sh0000_4000;
    endcase
  endfunction

  task automatic random_polygons(int count, int mode);
    int n;
    while (count > 0) begin
      n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
      for (int i = 0; i < n; i++)
        send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
      count -= n;
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_vertex_x = '0; in_vertex_y = '0; in_vertex_z = '0;
    in_final_vertex = 0;
    burst_left = 0;
    in_hold = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: plane z = 0, tight band
    send_vertex(32'sh0001_0000, 0, -32'sh0002_0000, 0);
    send_vertex(32'sh0002_0000, 0, 32'sh0002_0000, 0);
    send_vertex(0, 32'sh0001_0000, 100, 1);
    send_vertex(0, 0, 32'sh0001_0000, 1);
    send_vertex(0, 0, -32'sh0001_0000, 1);
    send_vertex(5, 5, 32'sh0001_0000, 0);
    send_vertex(7, 7, 32'sh0002_0000, 1);
    send_vertex(1, 2, -32'sh0001_0000, 0);
    send_vertex(3, 4, -32'sh0001_0000, 0);
    send_vertex(9, 9, 32'sh0001_0000, 1);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1);
    send_vertex(0, 0, 655, 0);
    send_vertex(0, 0, -655, 0);
    send_vertex(0, 0, 656, 1);
    wait_idle();

    write_reg(REG_NORMAL_X, 32'h0002_0000);
    write_reg(REG_NORMAL_Y, 32'h0002_0000);
    write_reg(REG_NORMAL_Z, 32'h0002_0000);
    write_reg(REG_OFFSET, 32'h7FFF_FFFF);
    write_reg(REG_EPSILON, 32'h0000_FFFF);
    write_reg(REG_NONE, 32'hFFFF_FFFF);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0);
    send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
    send_vertex(0, 0, 0, 1);
    random_polygons(40, 0);
    wait_idle();

    write_reg(REG_NORMAL_X, 32'h0001_FFFF);
    write_reg(REG_NORMAL_Y, 32'h0003_0000);
    write_reg(REG_NORMAL_Z, 32'h0000_0000);
    write_reg(REG_OFFSET, 32'h8000_0000);
    write_reg(REG_EPSILON, 32'h0000_0000);
    random_polygons(60, 0);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_NORMAL_X, $urandom);
      write_reg(REG_NORMAL_Y, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(REG_NORMAL_Z, $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
      write_reg(REG_OFFSET, (ph % 2) ? $urandom : $urandom_range(0, 32'h0004_0000)
                - 32'h0002_0000);
      write_reg(REG_EPSILON, (ph == 3) ? $urandom : $urandom_range(0, 2000));
      random_polygons(60, 1 + ph % 2);
      wait_idle();
    end

    if (fail_count == 0)
      $display("[polygon_plane_clip_core] OK");
    else
      $display("[polygon_plane_clip_core] ERROR");
    $finish;
  end
endmodule
